[design/cts_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cts_pkg - shared types and codes for the charstring token splitter
// Type 2 charstring lead byte codes, limits and the token result record.
// ----------------------------------------------------------------------------
package cts_pkg;

    // Limits
    localparam int unsigned MAX_HINTS         = 96;
    localparam int unsigned SHORT_TOKEN_BYTES = 4;
    localparam int unsigned STACK_MAX         = 63;

    // Field widths
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned LEN_W   = 4;
    localparam int unsigned WORD_W  = 32;
    localparam int unsigned ACCUM_W = 24;
    localparam int unsigned HINT_W  = 7;
    localparam int unsigned STACK_W = 6;

    // Operator leads
    localparam logic [7:0] OP_HSTEM     = 8'd1;
    localparam logic [7:0] OP_VSTEM     = 8'd3;
    localparam logic [7:0] OP_ESCAPE    = 8'd12;
    localparam logic [7:0] OP_HSTEMHM   = 8'd18;
    localparam logic [7:0] OP_HINTMASK  = 8'd19;
    localparam logic [7:0] OP_CNTRMASK  = 8'd20;
    localparam logic [7:0] OP_VSTEMHM   = 8'd23;

    // Operand leads
    localparam logic [7:0] LEAD_SHORTINT = 8'd28;
    localparam logic [7:0] LEAD_ONE_MIN  = 8'd32;
    localparam logic [7:0] LEAD_TWO_MIN  = 8'd247;
    localparam logic [7:0] LEAD_FIXED    = 8'd255;

    // One emitted token
    typedef struct packed {
        logic [LEN_W-1:0]  token_len;
        logic [BYTE_W-1:0] lead_byte;
        logic [WORD_W-1:0] packed_value;
        logic              is_operator;
        logic              charstring_end;
        logic              truncated;
    } tok_result_t;

    // Operator leads are all codes below 32 except the short integer lead
    function automatic logic lead_is_operator(input logic [7:0] b);
        return (b < LEAD_ONE_MIN) && (b != LEAD_SHORTINT);
    endfunction

endpackage

[design/cts_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cts_if - stream channels of the charstring token splitter
// Byte channel into the block and token channel out of it, valid/ready.
// ----------------------------------------------------------------------------
interface cts_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_in_charstring;

    modport source (output valid, output data_byte, output last_in_charstring, input ready);
    modport sink   (input valid, input data_byte, input last_in_charstring, output ready);
endinterface

interface cts_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  token_len;
    logic [7:0]  lead_byte;
    logic [31:0] packed_value;
    logic        is_operator;
    logic        charstring_end;
    logic        truncated;

    modport source (
        output valid, output token_len, output lead_byte, output packed_value,
        output is_operator, output charstring_end, output truncated, input ready
    );
    modport sink (
        input valid, input token_len, input lead_byte, input packed_value,
        input is_operator, input charstring_end, input truncated, output ready
    );
endinterface

[design/cts_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cts_core - tokenizer state and per-byte step
// Holds the token and hint/stack state, works out one byte per fire and
// flags when a token is complete or cut off by the end of the charstring.
// ----------------------------------------------------------------------------
module cts_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  logic [7:0]          data_byte,
    input  logic                cs_last,
    output logic                emit,
    output cts_pkg::tok_result_t result
);

    logic [3:0]  bytes_left_reg, bytes_left_next;
    logic [3:0]  seen_reg, seen_next;
    logic [7:0]  lead_reg, lead_next;
    logic [23:0] accum_reg, accum_next;
    logic [6:0]  hint_reg, hint_next;
    logic [5:0]  stack_reg, stack_next;

    logic        lead_op;
    logic        stem_op;
    logic        mask_op;
    logic [7:0]  hint_sum;
    logic [6:0]  hint_sat;
    logic [7:0]  mask_round;
    logic [3:0]  len_m1;

    // Hint count after stems: saturating add of half the stack
    always_comb
    begin
        lead_op  = cts_pkg::lead_is_operator(data_byte);
        mask_op  = (data_byte == cts_pkg::OP_HINTMASK) || (data_byte == cts_pkg::OP_CNTRMASK);
        stem_op  = lead_op && (mask_op
                   || (data_byte == cts_pkg::OP_HSTEM)   || (data_byte == cts_pkg::OP_VSTEM)
                   || (data_byte == cts_pkg::OP_HSTEMHM) || (data_byte == cts_pkg::OP_VSTEMHM));
        hint_sum = {1'b0, hint_reg} + {3'b000, stack_reg[5:1]};
        if (hint_sum > 8'(cts_pkg::MAX_HINTS))
            hint_sat = 7'(cts_pkg::MAX_HINTS);
        else
            hint_sat = hint_sum[6:0];
        mask_round = {1'b0, hint_sat} + 8'd7;
    end

    // Bytes owed after the lead
    always_comb
    begin
        len_m1 = 4'd0;
        if (lead_op)
        begin
            if (data_byte == cts_pkg::OP_ESCAPE)
                len_m1 = 4'd1;
            else if (mask_op)
                len_m1 = mask_round[6:3];
        end
        else
        begin
            priority if (data_byte == cts_pkg::LEAD_SHORTINT)
                len_m1 = 4'd2;
            else if (data_byte < cts_pkg::LEAD_TWO_MIN)
                len_m1 = 4'd0;
            else if (data_byte < cts_pkg::LEAD_FIXED)
                len_m1 = 4'd1;
            else
                len_m1 = 4'd4;
        end
    end

    // Step: start a token or fill the open one
    always_comb
    begin
        lead_next  = lead_reg;
        hint_next  = hint_reg;
        stack_next = stack_reg;
        accum_next = accum_reg;
        seen_next  = seen_reg;
        if (bytes_left_reg == 4'd0)
        begin
            lead_next       = data_byte;
            seen_next       = 4'd1;
            accum_next      = {data_byte, 16'h0000};
            bytes_left_next = len_m1;
            if (stem_op)
                hint_next = hint_sat;
            if (lead_op)
                stack_next = '0;
            else if (stack_reg < 6'(cts_pkg::STACK_MAX))
                stack_next = stack_reg + 6'd1;
        end
        else
        begin
            unique case (seen_reg)
                4'd0:    accum_next = accum_reg | {data_byte, 16'h0000};
                4'd1:    accum_next = accum_reg | {8'h00, data_byte, 8'h00};
                4'd2:    accum_next = accum_reg | {16'h0000, data_byte};
                default: accum_next = accum_reg;
            endcase
            if (seen_reg < 4'd15)
                seen_next = seen_reg + 4'd1;
            bytes_left_next = bytes_left_reg - 4'd1;
        end
    end

    // Result record from the stepped state
    always_comb
    begin
        emit                  = (bytes_left_next == 4'd0) || cs_last;
        result.token_len      = seen_next;
        result.lead_byte      = lead_next;
        if (seen_next < 4'(cts_pkg::SHORT_TOKEN_BYTES))
            result.packed_value = {4'h0, seen_next, accum_next};
        else
            result.packed_value = {4'h0, seen_next, lead_next, 16'h0000};
        result.is_operator    = cts_pkg::lead_is_operator(lead_next);
        result.charstring_end = cs_last;
        result.truncated      = (bytes_left_next != 4'd0);
    end

    // Advance state; clear token on emit, hint/stack at charstring end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_left_reg <= '0;
            seen_reg       <= '0;
            lead_reg       <= '0;
            accum_reg      <= '0;
            hint_reg       <= '0;
            stack_reg      <= '0;
        end
        else if (fire)
        begin
            if (emit)
            begin
                bytes_left_reg <= '0;
                seen_reg       <= '0;
                lead_reg       <= '0;
                accum_reg      <= '0;
            end
            else
            begin
                bytes_left_reg <= bytes_left_next;
                seen_reg       <= seen_next;
                lead_reg       <= lead_next;
                accum_reg      <= accum_next;
            end
            if (cs_last)
            begin
                hint_reg  <= '0;
                stack_reg <= '0;
            end
            else
            begin
                hint_reg  <= hint_next;
                stack_reg <= stack_next;
            end
        end
    end

`ifndef SYNTH
    a_left_bound: assert property (@(posedge clk) disable iff (!rst_n)
        bytes_left_reg <= 4'd12)
        else $error("bytes owed exceed longest mask token");

    a_hint_bound: assert property (@(posedge clk) disable iff (!rst_n)
        hint_reg <= 7'(cts_pkg::MAX_HINTS))
        else $error("hint count above saturation limit");

    a_open_token: assert property (@(posedge clk) disable iff (!rst_n)
        (bytes_left_reg == 4'd0) == (seen_reg == 4'd0))
        else $error("open token bookkeeping out of step");

    a_end_clear: assert property (@(posedge clk) disable iff (!rst_n)
        fire && cs_last |=> (hint_reg == '0) && (stack_reg == '0) && (bytes_left_reg == '0))
        else $error("state not cleared at charstring end");
`endif

endmodule

[design/charstring_token_splitter_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// charstring_token_splitter_unit - Type 2 charstring tokenizer
// Splits a charstring byte stream into operand and operator tokens.
// ----------------------------------------------------------------------------
// Usage:
//   char_bytes takes one charstring byte per beat, with last_in_charstring
//   on the final byte of each charstring. tokens gives one beat per finished
//   token: length, lead byte, packed value, operator flag, end and truncation.
//   A byte is accepted every cycle while tokens keeps up; a byte that does
//   not finish a token produces no beat. The byte lands in an input register,
//   is worked through the tokenizer step and its token is offered from the
//   result register. Throughput is set by the one-byte state update: one byte
//   per cycle while tokens keeps up. When tokens stalls, the result register
//   holds its beat and the input register holds one more byte; char_bytes
//   drops ready only when both are full. Reset clears all token, hint and
//   stack state and empties both registers; the end of each charstring
//   clears the same state.
// ----------------------------------------------------------------------------
module charstring_token_splitter_unit (
    input  logic      clk,
    input  logic      rst_n,
    cts_in_if.sink    char_bytes,
    cts_out_if.source tokens
);

    logic                 in_valid_reg, in_valid_next;
    logic [7:0]           in_byte_reg;
    logic                 in_last_reg;
    logic                 out_valid_reg, out_valid_next;
    cts_pkg::tok_result_t out_data_reg;

    logic                 out_free;
    logic                 advance;
    logic                 in_take;
    logic                 emit;
    cts_pkg::tok_result_t step_result;

    // Handshake: drain input register when result register can take a beat
    always_comb
    begin
        out_free         = !out_valid_reg || tokens.ready;
        advance          = in_valid_reg && out_free;
        char_bytes.ready = !in_valid_reg || advance;
        in_take          = char_bytes.valid && char_bytes.ready;
        in_valid_next    = in_take || (in_valid_reg && !advance);
        out_valid_next   = (advance && emit) || (out_valid_reg && !tokens.ready);
    end

    cts_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (advance),
        .data_byte (in_byte_reg),
        .cs_last   (in_last_reg),
        .emit      (emit),
        .result    (step_result)
    );

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg <= char_bytes.data_byte;
            in_last_reg <= char_bytes.last_in_charstring;
        end
        if (advance && emit)
            out_data_reg <= step_result;
    end

    // Drive token channel
    assign tokens.valid          = out_valid_reg;
    assign tokens.token_len      = out_data_reg.token_len;
    assign tokens.lead_byte      = out_data_reg.lead_byte;
    assign tokens.packed_value   = out_data_reg.packed_value;
    assign tokens.is_operator    = out_data_reg.is_operator;
    assign tokens.charstring_end = out_data_reg.charstring_end;
    assign tokens.truncated      = out_data_reg.truncated;

endmodule
